### hw/rtl/modem_response_deframer_assert.svh
// Assertion macros for the modem response deframer checker.
// No dependencies; included by the checker file.
`ifndef MODEM_RESPONSE_DEFRAMER_ASSERT_SVH
`define MODEM_RESPONSE_DEFRAMER_ASSERT_SVH

// Clocked property, disabled while reset is high.
`define MRD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mrd assertion failed");

// Clocked property that also holds through reset.
`define MRD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mrd assertion failed");

`endif

### hw/rtl/mrd_pkg.sv
// Types and constants shared by the modem response deframer files.
// No dependencies.
package mrd_pkg;

   localparam int unsigned RX_BYTE_W  = 8;
   localparam int unsigned KIND_W     = 4;
   localparam int unsigned TOTAL_W    = 17;
   localparam int unsigned LENGTH_W   = 16;
   localparam int unsigned TYPE_W     = 7;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [LENGTH_W-1:0]  LENGTH_LIMIT_RESET = 16'd100;
   localparam logic [TOTAL_W-1:0]   HDR_BYTES          = 17'd5;
   localparam logic [RX_BYTE_W-1:0] NAK_CODE           = 8'h15;

   // frame byte positions
   localparam logic [TOTAL_W-1:0] POS_START   = 17'd0;
   localparam logic [TOTAL_W-1:0] POS_LEN_LO  = 17'd1;
   localparam logic [TOTAL_W-1:0] POS_LEN_HI  = 17'd2;
   localparam logic [TOTAL_W-1:0] POS_TYPE    = 17'd3;
   localparam logic [TOTAL_W-1:0] POS_FLAGS   = 17'd4;
   localparam logic [TOTAL_W-1:0] POS_STATUS  = 17'd5;
   localparam logic [TOTAL_W-1:0] POS_SPACE   = 17'd8;
   localparam logic [TOTAL_W-1:0] POS_USED    = 17'd9;
   localparam logic [TOTAL_W-1:0] PAYLOAD_OFS = 17'd4;

   // register index, taken from paddr[2]
   localparam logic REG_LENGTH_LIMIT = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_STATUS   = 4'd0,
      KIND_VERSION  = 4'd1,
      KIND_SERIAL   = 4'd2,
      KIND_GETCFG   = 4'd3,
      KIND_SETCFG   = 4'd4,
      KIND_PREAMBLE = 4'd5,
      KIND_START    = 4'd6,
      KIND_HEADER   = 4'd7,
      KIND_SYNC     = 4'd8,
      KIND_DATA     = 4'd9,
      KIND_EOT      = 4'd10,
      KIND_LOST     = 4'd11,
      KIND_TESTMODE = 4'd12,
      KIND_UNKNOWN  = 4'd13,
      KIND_LENERR   = 4'd14
   } kind_type;

   localparam logic [TYPE_W-1:0] TYPE_BASE     = 7'h10;
   localparam logic [TYPE_W-1:0] TYPE_LAST     = 7'h1B;
   localparam logic [TYPE_W-1:0] TYPE_TESTMODE = 7'h1F;

   typedef struct packed {
      kind_type               kind;
      logic [TOTAL_W-1:0]     total_length;
      logic [RX_BYTE_W-1:0]   first_payload;
      logic                   nak_seen;
      logic                   header_good;
      logic                   tx_enabled;
      logic                   checksum_on;
      logic                   transmitting;
      logic [RX_BYTE_W-1:0]   tx_space;
      logic [RX_BYTE_W-1:0]   free_slots;
   } rsp_type;

   // Dense code for a type byte with its response bit already masked.
   function automatic kind_type map_kind(input logic [TYPE_W-1:0] t);
      kind_type k;
      if (t >= TYPE_BASE && t <= TYPE_LAST) begin
         k = kind_type'(t[KIND_W-1:0]);
      end else if (t == TYPE_TESTMODE) begin
         k = KIND_TESTMODE;
      end else begin
         k = KIND_UNKNOWN;
      end
      return k;
   endfunction

endpackage

### hw/rtl/mrd_channels_if.sv
// Valid/ready channel interfaces for the modem response deframer.
// Depends on mrd_pkg for field widths.
interface mrd_req_if;
   import mrd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [RX_BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrd_rsp_if;
   import mrd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [TOTAL_W-1:0]   total_length;
   logic [RX_BYTE_W-1:0] first_payload;
   logic                 nak_seen;
   logic                 header_good;
   logic                 tx_enabled;
   logic                 checksum_on;
   logic                 transmitting;
   logic [RX_BYTE_W-1:0] tx_space;
   logic [RX_BYTE_W-1:0] free_slots;

   modport source (output valid, output kind, output total_length, output first_payload,
                   output nak_seen, output header_good, output tx_enabled,
                   output checksum_on, output transmitting, output tx_space,
                   output free_slots, input ready);
   modport sink (input valid, input kind, input total_length, input first_payload,
                 input nak_seen, input header_good, input tx_enabled,
                 input checksum_on, input transmitting, input tx_space,
                 input free_slots, output ready);
endinterface

### hw/rtl/modem_response_deframer.sv
// Modem response deframer: cuts a received byte stream into response frames.
// Depends on mrd_pkg and the channel interfaces in mrd_channels_if.sv.
//
// req_ch carries one received byte per item. A frame is a start byte, a
// little-endian 16-bit length, a type byte and then length plus one
// further bytes. rsp_ch carries one item per frame, decoded from the type
// and the payload bytes at frame positions 4, 5, 8 and 9. A declared length
// at or above length_limit (csr register 0, byte address 0) ends the frame
// at the first payload byte with a length error item.
// Throughput: one byte per cycle while the receiver takes results. A byte
// is held in the input register; the frame logic then loads the result
// register, which drives rsp_ch.
// When the receiver stalls, the result register holds its item and the input
// register keeps taking bytes until it too is full; req_ch.ready then drops.
// Reset (synchronous) empties both registers, waits for a start byte and
// sets length_limit to 100.
module modem_response_deframer (
   input  logic                           clock,
   input  logic                           reset,
   mrd_req_if.sink                        req_ch,
   mrd_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mrd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mrd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mrd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import mrd_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [RX_BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic [TOTAL_W-1:0]   pos_ff, pos_in;
   logic [LENGTH_W-1:0]  dlen_ff, dlen_in;
   logic [TYPE_W-1:0]    type_ff, type_in;
   logic [RX_BYTE_W-1:0] cap_ff [4];
   logic [RX_BYTE_W-1:0] cap_in [4];
   logic [LENGTH_W-1:0]  limit_ff, limit_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   logic                 advance, fire, emit, lenerr, frame_end, csr_write;
   logic [TOTAL_W-1:0]   total;
   rsp_type              res;

   assign advance   = !out_valid_ff || rsp_ch.ready;
   assign fire      = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_LENGTH_LIMIT);
   assign csr_prdata = (csr_paddr[2] == REG_LENGTH_LIMIT)
                       ? {{(CSR_DATA_W-LENGTH_W){1'b0}}, limit_ff} : '0;

   assign total     = {1'b0, dlen_ff} + HDR_BYTES;
   assign lenerr    = (pos_ff == POS_FLAGS) && (dlen_ff >= limit_ff);
   assign frame_end = pos_ff >= ({1'b0, dlen_ff} + PAYLOAD_OFS);

   always_comb begin
      pos_in  = pos_ff;
      dlen_in = dlen_ff;
      type_in = type_ff;
      cap_in  = cap_ff;
      emit    = 1'b0;
      res     = '0;
      res.kind = KIND_LENERR;

      if (pos_ff == POS_START) begin
         cap_in = '{default: '0};
         pos_in = POS_LEN_LO;
      end else if (pos_ff == POS_LEN_LO) begin
         dlen_in = {{(LENGTH_W-RX_BYTE_W){1'b0}}, in_byte_ff};
         pos_in  = POS_LEN_HI;
      end else if (pos_ff == POS_LEN_HI) begin
         dlen_in = {in_byte_ff, dlen_ff[RX_BYTE_W-1:0]};
         pos_in  = POS_TYPE;
      end else if (pos_ff == POS_TYPE) begin
         type_in = in_byte_ff[TYPE_W-1:0];
         pos_in  = POS_FLAGS;
      end else begin
         if (pos_ff == POS_FLAGS)  cap_in[0] = in_byte_ff;
         if (pos_ff == POS_STATUS) cap_in[1] = in_byte_ff;
         if (pos_ff == POS_SPACE)  cap_in[2] = in_byte_ff;
         if (pos_ff == POS_USED)   cap_in[3] = in_byte_ff;

         if (lenerr) begin
            // abort frame: only kind and length are reported
            emit = 1'b1;
            res.total_length = total;
            pos_in = POS_START;
         end else if (!frame_end) begin
            pos_in = pos_ff + 17'd1;
         end else begin
            emit   = 1'b1;
            pos_in = POS_START;
            res.kind          = map_kind(type_ff);
            res.total_length  = total;
            res.first_payload = cap_in[0];
            if (res.kind == KIND_HEADER || res.kind == KIND_DATA) begin
               res.nak_seen    = (total == (HDR_BYTES + 17'd2)) && (cap_in[0] == NAK_CODE);
               res.header_good = !cap_in[1][7];
            end
            if (res.kind == KIND_STATUS) begin
               res.tx_enabled   = cap_in[0][1];
               res.checksum_on  = cap_in[0][3];
               res.transmitting = cap_in[1][1];
               res.tx_space     = cap_in[2];
               res.free_slots   = (cap_in[2] >= cap_in[3]) ? (cap_in[2] - cap_in[3]) : '0;
            end
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
         in_byte_in  = req_ch.rx_byte;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (fire && emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      limit_in = csr_write ? csr_pwdata[LENGTH_W-1:0] : limit_ff;
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= POS_START;
         dlen_ff      <= '0;
         type_ff      <= '0;
         cap_ff       <= '{default: '0};
         limit_ff     <= LENGTH_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         limit_ff     <= limit_in;
         if (fire) begin
            pos_ff  <= pos_in;
            dlen_ff <= dlen_in;
            type_ff <= type_in;
            cap_ff  <= cap_in;
         end
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.kind          = out_ff.kind;
   assign rsp_ch.total_length  = out_ff.total_length;
   assign rsp_ch.first_payload = out_ff.first_payload;
   assign rsp_ch.nak_seen      = out_ff.nak_seen;
   assign rsp_ch.header_good   = out_ff.header_good;
   assign rsp_ch.tx_enabled    = out_ff.tx_enabled;
   assign rsp_ch.checksum_on   = out_ff.checksum_on;
   assign rsp_ch.transmitting  = out_ff.transmitting;
   assign rsp_ch.tx_space      = out_ff.tx_space;
   assign rsp_ch.free_slots    = out_ff.free_slots;

endmodule

### hw/rtl/mrd_checker.sv
// Port-level checker for the modem response deframer, bound to the top level.
// Depends on mrd_pkg and modem_response_deframer_assert.svh.
`include "modem_response_deframer_assert.svh"

module mrd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mrd_pkg::KIND_W-1:0]    rsp_kind,
   input logic [mrd_pkg::TOTAL_W-1:0]   rsp_total_length,
   input logic [mrd_pkg::RX_BYTE_W-1:0] rsp_first_payload,
   input logic                          rsp_nak_seen,
   input logic                          rsp_tx_enabled,
   input logic [mrd_pkg::RX_BYTE_W-1:0] rsp_tx_space,
   input logic [mrd_pkg::RX_BYTE_W-1:0] rsp_free_slots
);
   import mrd_pkg::*;

   `MRD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)
   `MRD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `MRD_ASSERT(a_lenerr_bare, clock, reset,
      rsp_valid && (rsp_kind == KIND_LENERR) |->
         (rsp_first_payload == '0) && !rsp_tx_enabled && (rsp_tx_space == '0))
   `MRD_ASSERT(a_free_in_space, clock, reset,
      rsp_valid |-> (rsp_free_slots <= rsp_tx_space))
   `MRD_ASSERT(a_nak_frame, clock, reset,
      rsp_valid && rsp_nak_seen |->
         (rsp_total_length == (HDR_BYTES + 17'd2)) && (rsp_first_payload == NAK_CODE))

endmodule

bind modem_response_deframer mrd_checker u_mrd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_kind          (rsp_ch.kind),
   .rsp_total_length  (rsp_ch.total_length),
   .rsp_first_payload (rsp_ch.first_payload),
   .rsp_nak_seen      (rsp_ch.nak_seen),
   .rsp_tx_enabled    (rsp_ch.tx_enabled),
   .rsp_tx_space      (rsp_ch.tx_space),
   .rsp_free_slots    (rsp_ch.free_slots)
);
